### rtl/fmrc_pkg.sv
// shared types, constants and helpers for the frame max rendered counter
// no dependencies
package fmrc_pkg;

    localparam int unsigned USE_CASE_SLOTS_DEF = 256;
    localparam int unsigned CODE_W             = 8;
    localparam int unsigned CH_W               = 16;
    localparam int unsigned TOTAL_W            = 32;
    localparam logic [CODE_W-1:0] ALWAYS_CODE_RST = 8'hFF;

    typedef enum logic [1:0] {
        MODE_OBJECT = 2'd0,
        MODE_BED    = 2'd1,
        MODE_SUBBED = 2'd2,
        MODE_EOF    = 2'd3
    } mode_t;

    // saturating sum with its overflow mark
    typedef struct packed {
        logic               ovf;
        logic [TOTAL_W-1:0] val;
    } sat_sum_t;

    // requests from the frame logic to the use case table
    typedef struct packed {
        logic              rd_en;
        logic [CODE_W-1:0] rd_use_case;
        logic              wr_en;
        logic              clr;
    } tbl_ctrl_t;

    function automatic sat_sum_t sat_add(input logic [TOTAL_W-1:0] a,
                                         input logic [TOTAL_W-1:0] b);
        logic [TOTAL_W:0] s;
        sat_sum_t r;
        s = {1'b0, a} + {1'b0, b};
        r.ovf = s[TOTAL_W];
        r.val = s[TOTAL_W] ? {TOTAL_W{1'b1}} : s[TOTAL_W-1:0];
        return r;
    endfunction

endpackage

### rtl/fmrc_elem_if.sv
// element request channel: valid, ready and element fields
// depends on fmrc_pkg for field widths
interface fmrc_elem_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    mode;
    logic                          included;
    logic                          conditional;
    logic [fmrc_pkg::CODE_W-1:0]   use_case;
    logic [fmrc_pkg::CH_W-1:0]     channel_count;

    modport source (output valid, mode, included, conditional, use_case, channel_count,
                    input ready);
    modport sink   (input valid, mode, included, conditional, use_case, channel_count,
                    output ready);
endinterface

### rtl/fmrc_result_if.sv
// result request channel: valid, ready and frame count fields
// depends on fmrc_pkg for field widths
interface fmrc_result_if;
    logic                          valid;
    logic                          ready;
    logic [fmrc_pkg::TOTAL_W-1:0]  max_rendered;
    logic                          overflow;

    modport source (output valid, max_rendered, overflow, input ready);
    modport sink   (input valid, max_rendered, overflow, output ready);
endinterface

### rtl/fmrc_case_table.sv
// per use case totals: memory with registered read, write bypass and valid bits
// depends on fmrc_pkg
module fmrc_case_table #(
    parameter int unsigned USE_CASE_SLOTS = fmrc_pkg::USE_CASE_SLOTS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  fmrc_pkg::tbl_ctrl_t          ctrl,
    input  logic [fmrc_pkg::TOTAL_W-1:0] wr_data,
    output logic [fmrc_pkg::TOTAL_W-1:0] cur_total
);

    localparam int unsigned SLOT_W  = (USE_CASE_SLOTS > 1) ? $clog2(USE_CASE_SLOTS) : 1;
    localparam int unsigned N_CODES = 1 << fmrc_pkg::CODE_W;

    logic [SLOT_W-1:0]            slot_lut [N_CODES];
    logic [fmrc_pkg::TOTAL_W-1:0] mem [USE_CASE_SLOTS];
    logic [SLOT_W-1:0]            rd_slot;
    logic [SLOT_W-1:0]            slot_reg;
    logic [fmrc_pkg::TOTAL_W-1:0] rd_data_reg;
    logic [fmrc_pkg::TOTAL_W-1:0] byp_data_reg;
    logic                         byp_reg;
    logic                         byp_next;
    logic [USE_CASE_SLOTS-1:0]    valid_reg;
    logic [USE_CASE_SLOTS-1:0]    valid_next;

    // use case code to slot
    for (genvar v = 0; v < N_CODES; v++)
    begin : g_lut
        assign slot_lut[v] = SLOT_W'(v % USE_CASE_SLOTS);
    end

    assign rd_slot  = slot_lut[ctrl.rd_use_case];
    assign byp_next = ctrl.wr_en && (slot_reg == rd_slot);

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[slot_reg] <= wr_data;
        end
        if (ctrl.rd_en)
        begin
            rd_data_reg  <= mem[rd_slot];
            byp_data_reg <= wr_data;
            slot_reg     <= rd_slot;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (ctrl.clr)
        begin
            valid_next = '0;
        end
        else if (ctrl.wr_en)
        begin
            valid_next[slot_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_reg   <= 1'b0;
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (ctrl.rd_en)
            begin
                byp_reg <= byp_next;
            end
        end
    end

    // unwritten slots of this frame read as zero
    assign cur_total = !valid_reg[slot_reg] ? '0 :
                       byp_reg ? byp_data_reg : rd_data_reg;

endmodule

### rtl/frame_max_rendered_counter_core.sv
// frame max rendered counter: accumulates worst-case rendered count per frame
// depends on fmrc_pkg, fmrc_elem_if, fmrc_result_if and fmrc_case_table
// result path: an accepted end of frame request is registered in stage 1, then its count in the result register
// throughput: one element request per cycle when not stalled; table read-modify-write overlaps via bypass
// stalls only while an end of frame result waits on a full result register
// reset: frame totals, open bed and flags cleared, always code 255, no clearing pass
module frame_max_rendered_counter_core #(
    parameter int unsigned USE_CASE_SLOTS = fmrc_pkg::USE_CASE_SLOTS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [fmrc_pkg::CODE_W-1:0] cfg_wdata,
    fmrc_elem_if.sink                   elem,
    fmrc_result_if.source               result
);

    localparam int unsigned TW = fmrc_pkg::TOTAL_W;
    localparam int unsigned CW = fmrc_pkg::CH_W;

    logic [fmrc_pkg::CODE_W-1:0] code_reg;

    logic                        s1_valid_reg;
    logic                        s1_valid_next;
    fmrc_pkg::mode_t             s1_mode_reg;
    logic                        s1_inc_reg;
    logic                        s1_cond_reg;
    logic [fmrc_pkg::CODE_W-1:0] s1_uc_reg;
    logic [CW-1:0]               s1_ch_reg;

    logic [TW-1:0]               base_reg;
    logic [TW-1:0]               base_next;
    logic [TW-1:0]               run_max_reg;
    logic [TW-1:0]               run_max_next;
    logic [CW-1:0]               bed_ch_reg;
    logic [CW-1:0]               bed_ch_next;
    logic                        bed_act_reg;
    logic                        bed_act_next;
    logic                        sat_reg;
    logic                        sat_next;

    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [TW-1:0]               out_max_reg;
    logic                        out_ovf_reg;

    logic                        accept;
    logic                        fire;
    logic                        uncond;
    logic                        emit;
    logic [TW-1:0]               amount;
    logic [TW-1:0]               cur_total;
    fmrc_pkg::sat_sum_t          closed;
    fmrc_pkg::sat_sum_t          base_closed;
    fmrc_pkg::sat_sum_t          obj_sum;
    fmrc_pkg::sat_sum_t          case_sum;
    fmrc_pkg::sat_sum_t          frame_sum;
    fmrc_pkg::tbl_ctrl_t         tbl_ctrl;

    assign fire   = s1_valid_reg &&
                    (s1_mode_reg != fmrc_pkg::MODE_EOF || !out_valid_reg || result.ready);
    assign accept = elem.valid && elem.ready;
    assign elem.ready = !s1_valid_reg || fire;

    assign uncond = !s1_cond_reg || (s1_uc_reg == code_reg);
    assign amount = (s1_mode_reg == fmrc_pkg::MODE_OBJECT) ? TW'(1) : TW'(s1_ch_reg);

    // close the open bed, then the per-element sums
    assign closed      = fmrc_pkg::sat_add(base_reg, TW'(bed_ch_reg));
    assign base_closed = bed_act_reg ? closed : fmrc_pkg::sat_sum_t'{ovf: 1'b0, val: base_reg};
    assign obj_sum     = fmrc_pkg::sat_add(base_closed.val, TW'(1));
    assign case_sum    = fmrc_pkg::sat_add(cur_total, amount);
    assign frame_sum   = fmrc_pkg::sat_add(base_closed.val, run_max_reg);

    always_comb
    begin
        base_next            = base_reg;
        run_max_next         = run_max_reg;
        bed_ch_next          = bed_ch_reg;
        bed_act_next         = bed_act_reg;
        sat_next             = sat_reg;
        emit                 = 1'b0;
        tbl_ctrl.rd_en       = accept;
        tbl_ctrl.rd_use_case = elem.use_case;
        tbl_ctrl.wr_en       = 1'b0;
        tbl_ctrl.clr         = 1'b0;
        if (fire)
        begin
            unique case (s1_mode_reg)
                fmrc_pkg::MODE_SUBBED:
                begin
                    if (bed_act_reg && s1_inc_reg && (s1_ch_reg > bed_ch_reg))
                    begin
                        bed_ch_next = s1_ch_reg;
                    end
                end
                fmrc_pkg::MODE_EOF:
                begin
                    emit         = 1'b1;
                    tbl_ctrl.clr = 1'b1;
                    base_next    = '0;
                    run_max_next = '0;
                    bed_ch_next  = '0;
                    bed_act_next = 1'b0;
                    sat_next     = 1'b0;
                end
                fmrc_pkg::MODE_OBJECT,
                fmrc_pkg::MODE_BED:
                begin
                    base_next    = base_closed.val;
                    sat_next     = sat_reg | base_closed.ovf;
                    bed_ch_next  = '0;
                    bed_act_next = 1'b0;
                    if (s1_inc_reg)
                    begin
                        if (!uncond)
                        begin
                            tbl_ctrl.wr_en = 1'b1;
                            sat_next       = sat_reg | base_closed.ovf | case_sum.ovf;
                            if (case_sum.val > run_max_reg)
                            begin
                                run_max_next = case_sum.val;
                            end
                        end
                        else if (s1_mode_reg == fmrc_pkg::MODE_OBJECT)
                        begin
                            base_next = obj_sum.val;
                            sat_next  = sat_reg | base_closed.ovf | obj_sum.ovf;
                        end
                        else
                        begin
                            bed_act_next = 1'b1;
                            bed_ch_next  = s1_ch_reg;
                        end
                    end
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end
    end

    fmrc_case_table #(
        .USE_CASE_SLOTS (USE_CASE_SLOTS)
    ) u_case_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (tbl_ctrl),
        .wr_data   (case_sum.val),
        .cur_total (cur_total)
    );

    assign s1_valid_next  = accept ? 1'b1 : (fire ? 1'b0 : s1_valid_reg);
    assign out_valid_next = emit ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);

    // element and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_mode_reg <= fmrc_pkg::mode_t'(elem.mode);
            s1_inc_reg  <= elem.included;
            s1_cond_reg <= elem.conditional;
            s1_uc_reg   <= elem.use_case;
            s1_ch_reg   <= elem.channel_count;
        end
        if (emit)
        begin
            out_max_reg <= frame_sum.val;
            out_ovf_reg <= sat_reg | base_closed.ovf | frame_sum.ovf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_reg      <= fmrc_pkg::ALWAYS_CODE_RST;
            s1_valid_reg  <= 1'b0;
            base_reg      <= '0;
            run_max_reg   <= '0;
            bed_ch_reg    <= '0;
            bed_act_reg   <= 1'b0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                code_reg <= cfg_wdata;
            end
            s1_valid_reg  <= s1_valid_next;
            base_reg      <= base_next;
            run_max_reg   <= run_max_next;
            bed_ch_reg    <= bed_ch_next;
            bed_act_reg   <= bed_act_next;
            sat_reg       <= sat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.max_rendered = out_max_reg;
    assign result.overflow     = out_ovf_reg;

endmodule

### tb/sv/tb_frame_max_rendered_counter_core.sv
// testbench for frame_max_rendered_counter_core: a directed element table and random
// frames, every frame count checked against a behavioural model or a typed total
// depends on fmrc_pkg, fmrc_elem_if, fmrc_result_if and the core itself
module tb_frame_max_rendered_counter_core;

    localparam int unsigned SLOTS      = fmrc_pkg::USE_CASE_SLOTS_DEF;
    localparam int          CYCLE_CAP  = 200000;
    localparam int          RAND_ITEMS = 1250;
    localparam int          PLAN_ROWS  = 24;

    typedef struct packed {
        fmrc_pkg::mode_t             mode;
        logic                        included;
        logic                        conditional;
        logic [fmrc_pkg::CODE_W-1:0] use_case;
        logic [fmrc_pkg::CH_W-1:0]   channel_count;
    } element_t;

    typedef struct packed {
        logic [fmrc_pkg::TOTAL_W-1:0] max_rendered;
        logic                         overflow;
    } frame_count_t;

    typedef struct packed {
        fmrc_pkg::mode_t              mode;
        logic                         inc;
        logic                         cond;
        logic [fmrc_pkg::CODE_W-1:0]  uc;
        logic [fmrc_pkg::CH_W-1:0]    ch;
        logic                         typed;
        logic [fmrc_pkg::TOTAL_W-1:0] total;
        logic                         ovf;
    } plan_row_t;

    // typed totals only where obvious, the rest from the model below
    localparam plan_row_t PLAN [PLAN_ROWS] = '{
        '{fmrc_pkg::MODE_EOF,    1'b0, 1'b0, 8'h00, 16'h0000, 1'b1, 32'h0, 1'b0},
        '{fmrc_pkg::MODE_SUBBED, 1'b1, 1'b0, 8'h00, 16'hFFFF, 1'b0, 32'h0, 1'b0},
        '{fmrc_pkg::MODE_OBJECT, 1'b1, 1'b0, 8'h00, 16'h0000, 1'b0, 32'h0, 1'b0},
        '{fmrc_pkg::MODE_OBJECT, 1'b0, 1'b0, 8'h00, 16'h0000, 1'b0, 32'h0, 1'b0},
        '{fmrc_pkg::MODE_OBJECT, 1'b1, 1'b1, 8'hFF, 16'h1234, 1'b0, 32'h0, 1'b0},
        '{fmrc_pkg::MODE_BED,    1'b1, 1'b0, 8'h00, 16'h0003, 1'b0, 32'h0, 1'b0},
        '{fmrc_pkg::MODE_SUBBED, 1'b1, 1'b0, 8'h00, 16'h0005, 1'b0, 32'h0, 1'b0},
        '{fmrc_pkg::MODE_SUBBED, 1'b0, 1'b0, 8'h00, 16'h0009, 1'b0, 32'h0, 1'b0},
        '{fmrc_pkg::MODE_SUBBED, 1'b1, 1'b1, 8'h07, 16'h0004, 1'b0, 32'h0, 1'b0},
        '{fmrc_pkg::MODE_BED,    1'b0, 1'b0, 8'h00, 16'h0064, 1'b0, 32'h0, 1'b0},
        '{fmrc_pkg::MODE_SUBBED, 1'b1, 1'b0, 8'h00, 16'h0032, 1'b0, 32'h0, 1'b0},
        '{fmrc_pkg::MODE_BED,    1'b1, 1'b1, 8'h03, 16'h000A, 1'b0, 32'h0, 1'b0},
        '{fmrc_pkg::MODE_SUBBED, 1'b1, 1'b0, 8'h00, 16'h003C, 1'b0, 32'h0, 1'b0},
        '{fmrc_pkg::MODE_OBJECT, 1'b1, 1'b1, 8'h03, 16'hFFFF, 1'b0, 32'h0, 1'b0},
        '{fmrc_pkg::MODE_OBJECT, 1'b1, 1'b1, 8'h00, 16'h0000, 1'b0, 32'h0, 1'b0},
        '{fmrc_pkg::MODE_OBJECT, 1'b1, 1'b0, 8'hAA, 16'hFFFF, 1'b0, 32'h0, 1'b0},
        '{fmrc_pkg::MODE_SUBBED, 1'b1, 1'b0, 8'h00, 16'h0046, 1'b0, 32'h0, 1'b0},
        '{fmrc_pkg::MODE_BED,    1'b1, 1'b0, 8'h00, 16'hFFFF, 1'b0, 32'h0, 1'b0},
        '{fmrc_pkg::MODE_SUBBED, 1'b1, 1'b0, 8'h00, 16'h0000, 1'b0, 32'h0, 1'b0},
        '{fmrc_pkg::MODE_EOF,    1'b1, 1'b1, 8'hFF, 16'hFFFF, 1'b0, 32'h0, 1'b0},
        '{fmrc_pkg::MODE_EOF,    1'b0, 1'b0, 8'h00, 16'h0000, 1'b1, 32'h0, 1'b0},
        '{fmrc_pkg::MODE_BED,    1'b1, 1'b1, 8'h00, 16'h0000, 1'b0, 32'h0, 1'b0},
        '{fmrc_pkg::MODE_BED,    1'b1, 1'b1, 8'hFE, 16'h0007, 1'b0, 32'h0, 1'b0},
        '{fmrc_pkg::MODE_EOF,    1'b1, 1'b0, 8'h00, 16'h0000, 1'b0, 32'h0, 1'b0}
    };

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_we;
    logic [fmrc_pkg::CODE_W-1:0] cfg_wdata;

    fmrc_elem_if   elem_ch ();
    fmrc_result_if res_ch ();

    frame_max_rendered_counter_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .elem      (elem_ch),
        .result    (res_ch)
    );

    // model state
    logic [fmrc_pkg::CODE_W-1:0]  always_code;
    logic [fmrc_pkg::TOTAL_W-1:0] uncond_total;
    logic [fmrc_pkg::TOTAL_W-1:0] peak_case_total;
    logic [fmrc_pkg::TOTAL_W-1:0] case_total [SLOTS];
    logic                         case_live [SLOTS];
    logic [fmrc_pkg::CH_W-1:0]    bed_channels;
    logic                         bed_open;
    logic                         clipped;

    frame_count_t pending_counts [$];
    int           errors;
    int           burst_left;
    logic         calm;

    function automatic logic [fmrc_pkg::TOTAL_W-1:0] clip_add(
        input logic [fmrc_pkg::TOTAL_W-1:0] a,
        input logic [fmrc_pkg::TOTAL_W-1:0] b);
        logic [fmrc_pkg::TOTAL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[fmrc_pkg::TOTAL_W])
            clipped = 1'b1;
        return s[fmrc_pkg::TOTAL_W] ? {fmrc_pkg::TOTAL_W{1'b1}} : s[fmrc_pkg::TOTAL_W-1:0];
    endfunction

    task automatic clear_frame_state;
        uncond_total    = '0;
        peak_case_total = '0;
        bed_channels    = '0;
        bed_open        = 1'b0;
        clipped         = 1'b0;
        for (int s = 0; s < SLOTS; s++)
        begin
            case_total[s] = '0;
            case_live[s]  = 1'b0;
        end
    endtask

    task automatic count_element(input element_t e, output logic done,
                                 output frame_count_t res);
        logic                         uncond;
        int                           slot;
        logic [fmrc_pkg::TOTAL_W-1:0] run_sum;
        done   = 1'b0;
        res    = '0;
        uncond = !e.conditional || (e.use_case == always_code);
        if (e.mode == fmrc_pkg::MODE_SUBBED)
        begin
            if (bed_open && e.included && e.channel_count > bed_channels)
                bed_channels = e.channel_count;
            return;
        end
        // any root element or end of frame closes the open bed
        if (bed_open)
            uncond_total = clip_add(uncond_total, fmrc_pkg::TOTAL_W'(bed_channels));
        bed_open     = 1'b0;
        bed_channels = '0;
        if (e.mode == fmrc_pkg::MODE_EOF)
        begin
            res.max_rendered = clip_add(uncond_total, peak_case_total);
            res.overflow     = clipped;
            done             = 1'b1;
            clear_frame_state();
        end
        else if (e.included)
        begin
            if (uncond && e.mode == fmrc_pkg::MODE_OBJECT)
                uncond_total = clip_add(uncond_total, fmrc_pkg::TOTAL_W'(1));
            else if (uncond)
            begin
                bed_open     = 1'b1;
                bed_channels = e.channel_count;
            end
            else
            begin
                slot    = int'(e.use_case) % SLOTS;
                run_sum = case_live[slot] ? case_total[slot] : '0;
                run_sum = clip_add(run_sum,
                                   (e.mode == fmrc_pkg::MODE_OBJECT)
                                       ? fmrc_pkg::TOTAL_W'(1)
                                       : fmrc_pkg::TOTAL_W'(e.channel_count));
                case_total[slot] = run_sum;
                case_live[slot]  = 1'b1;
                if (run_sum > peak_case_total)
                    peak_case_total = run_sum;
            end
        end
    endtask

    task automatic send(input element_t e, input logic typed, input frame_count_t want);
        logic         done;
        frame_count_t res;
        int           gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (!calm)
                gap = $urandom_range(0, 6);
        end
        burst_left--;
        @(negedge clk);
        if (gap > 0)
        begin
            elem_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        elem_ch.valid         <= 1'b1;
        elem_ch.mode          <= e.mode;
        elem_ch.included      <= e.included;
        elem_ch.conditional   <= e.conditional;
        elem_ch.use_case      <= e.use_case;
        elem_ch.channel_count <= e.channel_count;
        do
            @(posedge clk);
        while (elem_ch.ready !== 1'b1);
        count_element(e, done, res);
        if (done)
            pending_counts.push_back(typed ? want : res);
    endtask

    task automatic drain;
        @(negedge clk);
        elem_ch.valid <= 1'b0;
        while (pending_counts.size() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic write_always_code(input logic [fmrc_pkg::CODE_W-1:0] code);
        drain();
        cfg_wdata <= code;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we      <= 1'b0;
        always_code = code;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_CAP) @(posedge clk);
        $display("Mismatches found");
        $finish;
    end

    // receiver stall pattern: free running, light, heavy, then long holds
    initial
    begin
        int tick;
        int hold;
        res_ch.ready = 1'b0;
        tick         = 0;
        hold         = 0;
        forever
        begin
            @(negedge clk);
            tick++;
            case ((tick / 300) % 4)
                0:       res_ch.ready <= 1'b1;
                1:       res_ch.ready <= ($urandom_range(0, 3) != 0);
                2:       res_ch.ready <= 1'($urandom_range(0, 1));
                default:
                begin
                    hold = (hold + 1) % 11;
                    res_ch.ready <= (hold == 0);
                end
            endcase
        end
    end

    always @(posedge clk)
    begin : watch
        frame_count_t got;
        frame_count_t want;
        if (rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            got = {res_ch.max_rendered, res_ch.overflow};
            if (pending_counts.size() == 0)
            begin
                errors++;
                $display("%0t: result with none pending, max_rendered %0d overflow %0b",
                         $time, got.max_rendered, got.overflow);
            end
            else
            begin
                want = pending_counts.pop_front();
                if (got.max_rendered !== want.max_rendered)
                begin
                    errors++;
                    $display("%0t: max_rendered expected %0d got %0d",
                             $time, want.max_rendered, got.max_rendered);
                end
                if (got.overflow !== want.overflow)
                begin
                    errors++;
                    $display("%0t: overflow expected %0b got %0b",
                             $time, want.overflow, got.overflow);
                end
            end
        end
    end

    initial
    begin
        int                          sent;
        int                          n;
        int                          r;
        logic                        noise;
        element_t                    e;
        logic [fmrc_pkg::CODE_W-1:0] codes [6];

        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_wdata             = '0;
        elem_ch.valid         = 1'b0;
        elem_ch.mode          = fmrc_pkg::MODE_OBJECT;
        elem_ch.included      = 1'b0;
        elem_ch.conditional   = 1'b0;
        elem_ch.use_case      = '0;
        elem_ch.channel_count = '0;
        errors                = 0;
        burst_left            = 0;
        calm                  = 1'b0;
        always_code           = fmrc_pkg::ALWAYS_CODE_RST;
        clear_frame_state();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < PLAN_ROWS; i++)
        begin
            e = '{PLAN[i].mode, PLAN[i].inc, PLAN[i].cond, PLAN[i].uc, PLAN[i].ch};
            send(e, PLAN[i].typed, '{PLAN[i].total, PLAN[i].ovf});
        end

        codes[0] = 8'h00;
        codes[1] = 8'hFF;
        codes[2] = fmrc_pkg::CODE_W'($urandom_range(0, 255));
        codes[3] = fmrc_pkg::CODE_W'($urandom_range(0, 255));
        codes[4] = 8'h01;
        codes[5] = fmrc_pkg::CODE_W'($urandom_range(0, 255));
        sent     = 0;
        for (int ph = 0; ph < 6; ph++)
        begin
            write_always_code(codes[ph]);
            calm = (ph % 2 == 1);
            while (sent < RAND_ITEMS * (ph + 1) / 6)
            begin
                // mostly well-formed frames, some pure noise
                noise = ($urandom_range(0, 5) == 0);
                n     = $urandom_range(0, 14);
                for (int k = 0; k <= n; k++)
                begin
                    r = $urandom_range(0, 9);
                    if (k == n)
                        e.mode = fmrc_pkg::MODE_EOF;
                    else if (noise)
                        e.mode = fmrc_pkg::mode_t'($urandom_range(0, 3));
                    else
                        e.mode = (r < 4) ? fmrc_pkg::MODE_OBJECT
                               : (r < 7) ? fmrc_pkg::MODE_BED
                               : fmrc_pkg::MODE_SUBBED;
                    e.included    = noise ? 1'($urandom_range(0, 1))
                                          : 1'($urandom_range(0, 7) != 0);
                    e.conditional = 1'($urandom_range(0, 1));
                    r = $urandom_range(0, 9);
                    e.use_case = (r < 3) ? always_code
                               : (r < 7) ? fmrc_pkg::CODE_W'($urandom_range(0, 3))
                               : (r == 7) ? 8'hFF
                               : fmrc_pkg::CODE_W'($urandom_range(0, 255));
                    r = $urandom_range(0, 9);
                    e.channel_count = (r < 7) ? fmrc_pkg::CH_W'($urandom_range(0, 20))
                                    : (r == 7) ? 16'hFFFF
                                    : fmrc_pkg::CH_W'($urandom_range(0, 65535));
                    send(e, 1'b0, '0);
                    sent++;
                end
            end
        end

        drain();
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### filelist.f
rtl/fmrc_pkg.sv
rtl/fmrc_elem_if.sv
rtl/fmrc_result_if.sv
rtl/fmrc_case_table.sv
rtl/frame_max_rendered_counter_core.sv
tb/sv/tb_frame_max_rendered_counter_core.sv
